// ----- hw/rtl/mmbd_pkg.sv -----
// Package for the 2x2 box-filter mip level downsampler.
// Holds the payload structs, the register indexes and the sizing constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mmbd_pkg;

  localparam int unsigned MAX_WIDTH    = 4096;
  localparam int unsigned HEIGHT_LIMIT = 4096;
  localparam int unsigned LINE_DEPTH   = MAX_WIDTH / 2;
  localparam int unsigned LINE_AW      = $clog2(LINE_DEPTH);
  localparam int unsigned POS_W        = $clog2(MAX_WIDTH);
  localparam int unsigned DIM_W        = 13;
  localparam int unsigned CHAN_W       = 3;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned LANES        = 4;
  localparam int unsigned SUM_W        = 9;
  localparam int unsigned LINE_W       = LANES * SUM_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [CHAN_W-1:0] CHANNELS_RGB = 3'd3;
  localparam logic [CHAN_W-1:0] CHANNELS_RGBA = 3'd4;

  // How a destination pixel is formed from the registered sums.
  localparam logic [1:0] KIND_COPY = 2'd0;
  localparam logic [1:0] KIND_PAIR = 2'd1;
  localparam logic [1:0] KIND_QUAD = 2'd2;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       level_done;
  } pixel_out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mipmap_box_downsample.sv -----
// A result is registered in the middle stage and then in the output register.
// Throughput: one source pixel per cycle unless held off; the line store takes at most one
// write or one read per pixel. Input is held off only while the output register is full and
// stalled and the middle stage is occupied.
// Reset: position counters and pipeline valids clear; registers return to width 1, height 1,
// four channels. The line store is not cleared; every entry is written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module mipmap_box_downsample
  import mmbd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire pixel_in_t             in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output pixel_out_t                 out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [DIM_W-1:0]  src_width_q, src_height_q;
  logic [CHAN_W-1:0] channel_count_q;
  logic [POS_W-1:0]  col_q, col_d, row_q, row_d;
  logic [LANES-1:0][7:0] left_q;
  logic [DIM_W-1:0]  width, height;
  logic              w_one, h_one, is_rgb;
  logic [DIM_W-1:0]  last_col, last_row, col_inc, row_inc;
  logic [LANES-1:0][7:0]      px;
  logic [LANES-1:0][SUM_W-1:0] hsum;
  logic              in_accept, left_load, emit, done;
  logic [1:0]        kind;
  logic [LANES-1:0][SUM_W-1:0] s1_sum_d;

  logic              mem_we, mem_re;
  logic [LINE_W-1:0] mem_rdata;

  logic              s1_valid_q, s1_done_q;
  logic [1:0]        s1_kind_q;
  logic [LANES-1:0][SUM_W-1:0] s1_sum_q;
  logic [LANES-1:0][SUM_W-1:0] line_word;
  logic [LANES-1:0][7:0] res;
  logic              out_valid_q, out_take;
  pixel_out_t        out_q;

  // Effective dimensions: zero reads as one, oversize saturates.
  always_comb begin
    width  = src_width_q;
    height = src_height_q;
    if (src_width_q == '0) begin
      width = DIM_W'(1);
    end else if (src_width_q > DIM_W'(MAX_WIDTH)) begin
      width = DIM_W'(MAX_WIDTH);
    end
    if (src_height_q == '0) begin
      height = DIM_W'(1);
    end else if (src_height_q > DIM_W'(HEIGHT_LIMIT)) begin
      height = DIM_W'(HEIGHT_LIMIT);
    end
  end

  assign w_one    = (width == DIM_W'(1));
  assign h_one    = (height == DIM_W'(1));
  assign is_rgb   = (channel_count_q == CHANNELS_RGB);
  assign last_col = w_one ? '0 : {width[DIM_W-1:1], 1'b0} - DIM_W'(1);
  assign last_row = h_one ? '0 : {height[DIM_W-1:1], 1'b0} - DIM_W'(1);
  assign col_inc  = {1'b0, col_q} + DIM_W'(1);
  assign row_inc  = {1'b0, row_q} + DIM_W'(1);

  assign px[0] = in_data_i.red_in;
  assign px[1] = in_data_i.green_in;
  assign px[2] = in_data_i.blue_in;
  assign px[3] = is_rgb ? 8'd0 : in_data_i.alpha_in;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      hsum[k] = {1'b0, left_q[k]} + {1'b0, px[k]};
    end
  end

  assign out_take   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_take;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    left_load = 1'b0;
    emit      = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    kind      = KIND_COPY;
    s1_sum_d  = hsum;
    if (w_one && h_one) begin
      emit = 1'b1;
      for (int k = 0; k < LANES; k++) begin
        s1_sum_d[k] = {1'b0, px[k]};
      end
    end else if (w_one || h_one) begin
      if ((w_one ? row_q[0] : col_q[0]) == 1'b0) begin
        left_load = 1'b1;
      end else begin
        emit = 1'b1;
        kind = KIND_PAIR;
      end
    end else if (col_q[0] == 1'b0) begin
      left_load = 1'b1;
    end else if (row_q[0] == 1'b0) begin
      mem_we = in_accept;
    end else begin
      mem_re = in_accept;
      emit   = 1'b1;
      kind   = KIND_QUAD;
    end
    done = ({1'b0, col_q} == last_col) && ({1'b0, row_q} == last_row);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_inc >= width) begin
      col_d = '0;
      row_d = (row_inc >= height) ? '0 : row_inc[POS_W-1:0];
    end else begin
      col_d = col_inc[POS_W-1:0];
    end
  end

  // A horizontal pair sum is written in the even row and read at least one row
  // later, so a write and the read of the same entry never overlap.
  mmbd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (col_q[POS_W-1:1]),
    .wdata_i (hsum),
    .re_i    (mem_re),
    .raddr_i (col_q[POS_W-1:1]),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q     <= DIM_W'(1);
      src_height_q    <= DIM_W'(1);
      channel_count_q <= CHANNELS_RGBA;
      col_q           <= '0;
      row_q           <= '0;
      left_q          <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SRC_WIDTH: begin
          src_width_q <= cfg_data_i;
          col_q       <= '0;
          row_q       <= '0;
        end
        REG_SRC_HEIGHT: begin
          src_height_q <= cfg_data_i;
          col_q        <= '0;
          row_q        <= '0;
        end
        REG_CHANNEL_COUNT: begin
          channel_count_q <= cfg_data_i[CHAN_W-1:0];
          col_q           <= '0;
          row_q           <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_accept) begin
      col_q <= col_d;
      row_q <= row_d;
      if (left_load) begin
        left_q <= px;
      end
    end
  end

  // Middle stage: waits for the line store read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= emit;
    end else if (out_take) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      s1_sum_q  <= s1_sum_d;
      s1_kind_q <= kind;
      s1_done_q <= done;
    end
  end

  assign line_word = mem_rdata;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      res[k] = s1_sum_q[k][7:0];
      unique case (s1_kind_q)
        KIND_COPY: res[k] = s1_sum_q[k][7:0];
        KIND_PAIR: res[k] = s1_sum_q[k][8:1];
        KIND_QUAD: res[k] = 8'(({1'b0, line_word[k]} + {1'b0, s1_sum_q[k]}) >> 2);
        default:   res[k] = s1_sum_q[k][7:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && s1_valid_q) begin
      out_q.red_out    <= res[0];
      out_q.green_out  <= res[1];
      out_q.blue_out   <= res[2];
      out_q.alpha_out  <= res[3];
      out_q.level_done <= s1_done_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/mmbd_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the line store of pair sums. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mmbd_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // The read data holds until the next read, so a stalled reader keeps it.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mmbd_checker.sv -----
// Port-level checks for the mip level downsampler, bound to its top level.
// Depends on mmbd_pkg and mipmap_box_downsample.
`timescale 1ns / 1ps
`default_nettype none

module mmbd_checker
  import mmbd_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire pixel_out_t            out_data_o
);

  // A stalled result transaction stays offered.
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // The input is only held off when the output side is backed up.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // A result reaching an empty output came from a pixel accepted before the middle stage and the output register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result appeared without a matching input transaction");

endmodule

bind mipmap_box_downsample mmbd_checker u_mmbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ----- dv/mipmap_box_downsample_tb.sv -----
// Self-checking testbench for the 2x2 box-filter mip level downsampler.
// A predictor tracks the position, held pixel and line store and checks each destination pixel.
// Depends on mmbd_pkg and mipmap_box_downsample.
`timescale 1ns / 1ps

module mipmap_box_downsample_tb;
  import mmbd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [CFG_DATA_W-1:0] CFG_RGB  = CFG_DATA_W'(CHANNELS_RGB);
  localparam logic [CFG_DATA_W-1:0] CFG_RGBA = CFG_DATA_W'(CHANNELS_RGBA);
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned DRAIN_CYCLES  = 4;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned RANDOM_PIXELS = 600;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  pixel_in_t             in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  pixel_out_t            out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_SRC_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  mipmap_box_downsample DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor copy of the registers and the walking state.
  logic [DIM_W-1:0]  width_reg  = DIM_W'(1);
  logic [DIM_W-1:0]  height_reg = DIM_W'(1);
  logic [CHAN_W-1:0] chan_reg   = CHANNELS_RGBA;
  int unsigned       next_col   = 0;
  int unsigned       next_row   = 0;
  logic [7:0]        held_px [LANES];
  logic [SUM_W-1:0]  pair_sums [LINE_DEPTH][LANES];

  pixel_out_t  due_mip_pixels[$];
  pixel_out_t  want_px;
  int unsigned errors            = 0;
  int unsigned src_pixels_sent   = 0;
  int unsigned mip_pixels_seen   = 0;
  int unsigned levels_done       = 0;
  int unsigned levels_set        = 0;
  int unsigned input_held_cycles = 0;
  int unsigned cycle_count       = 0;

  // Sender and receiver idling controls.
  int unsigned gap_max      = 3;
  int unsigned burst_left   = 0;
  int unsigned stall_pct    = 25;
  int unsigned hold_request = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] raw, input int unsigned lim);
    if (raw == 0) return 1;
    if (raw > lim) return lim;
    return raw;
  endfunction

  // Works out what one accepted source pixel produces and advances the position.
  task automatic average_source_pixel(input pixel_in_t px);
    int unsigned w, h, col, row, pos, slot, last_col, last_row;
    logic [7:0]       ch   [LANES];
    logic [SUM_W-1:0] hsum [LANES];
    logic [9:0]       avg  [LANES];
    bit               emit;
    pixel_out_t       mip;
    w    = clamp_dim(width_reg, MAX_WIDTH);
    h    = clamp_dim(height_reg, HEIGHT_LIMIT);
    col  = next_col;
    row  = next_row;
    emit = 1'b0;
    ch[0] = px.red_in;
    ch[1] = px.green_in;
    ch[2] = px.blue_in;
    ch[3] = (chan_reg == CHANNELS_RGB) ? 8'h00 : px.alpha_in;
    foreach (avg[k]) avg[k] = '0;

    if (w == 1 && h == 1) begin
      foreach (avg[k]) avg[k] = 10'(ch[k]);
      emit = 1'b1;
    end else if (w == 1 || h == 1) begin
      pos = (w == 1) ? row : col;
      if ((pos & 1) == 0) begin
        held_px = ch;
      end else begin
        foreach (avg[k]) avg[k] = (10'(held_px[k]) + 10'(ch[k])) >> 1;
        emit = 1'b1;
      end
    end else if ((col & 1) == 0) begin
      held_px = ch;
    end else begin
      slot = col >> 1;
      foreach (hsum[k]) hsum[k] = SUM_W'(held_px[k]) + SUM_W'(ch[k]);
      if ((row & 1) == 0) begin
        pair_sums[slot] = hsum;
      end else begin
        foreach (avg[k]) avg[k] = (10'(pair_sums[slot][k]) + 10'(hsum[k])) >> 2;
        emit = 1'b1;
      end
    end

    if (emit) begin
      last_col = (w == 1) ? 0 : 2 * (w / 2) - 1;
      last_row = (h == 1) ? 0 : 2 * (h / 2) - 1;
      mip.red_out    = avg[0][7:0];
      mip.green_out  = avg[1][7:0];
      mip.blue_out   = avg[2][7:0];
      mip.alpha_out  = avg[3][7:0];
      mip.level_done = (col == last_col && row == last_row);
      due_mip_pixels.push_back(mip);
    end

    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
    next_col = col;
    next_row = row;
  endtask

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pixel_in_t rand_pixel();
    pixel_in_t p;
    p.red_in   = rand_channel();
    p.green_in = rand_channel();
    p.blue_in  = rand_channel();
    p.alpha_in = rand_channel();
    return p;
  endfunction

  function automatic pixel_in_t rgba(input logic [7:0] r, g, b, a);
    pixel_in_t p;
    p.red_in   = r;
    p.green_in = g;
    p.blue_in  = b;
    p.alpha_in = a;
    return p;
  endfunction

  // Offers one source pixel, holding it until the transaction completes.
  task automatic send_pixel(input pixel_in_t px);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_max > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, gap_max) - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (in_stall_o);
    src_pixels_sent++;
    average_source_pixel(px);
  endtask

  // Waits until every expected destination pixel has come out and the pipeline is empty.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_mip_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      REG_SRC_WIDTH:     width_reg  = value;
      REG_SRC_HEIGHT:    height_reg = value;
      REG_CHANNEL_COUNT: chan_reg   = value[CHAN_W-1:0];
      default: ;
    endcase
    // Only the real registers send the position back to the start of a frame.
    if (idx != REG_SPARE) begin
      next_col = 0;
      next_row = 0;
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_level(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic [CFG_DATA_W-1:0] chans);
    drain();
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_HEIGHT, h);
    write_reg(REG_CHANNEL_COUNT, chans);
    levels_set++;
  endtask

  task automatic test_copy_and_channels();
    send_pixel(rgba(8'h00, 8'hFF, 8'h00, 8'hFF));
    send_pixel(rgba(8'hFF, 8'h00, 8'hFF, 8'h00));
    set_level(DIM_W'(1), DIM_W'(1), CFG_RGB);
    send_pixel(rgba(8'h12, 8'h34, 8'h56, 8'hFF));
    set_level(DIM_W'(1), DIM_W'(1), 13'd0);
    send_pixel(rgba(8'hA5, 8'h5A, 8'hC3, 8'h3C));
    set_level(DIM_W'(1), DIM_W'(1), 13'd7);
    send_pixel(rgba(8'h01, 8'h80, 8'h7F, 8'hFE));
  endtask

  task automatic test_small_blocks();
    // Three full-scale pixels and one with alpha just below: the wide sums must not wrap.
    set_level(DIM_W'(2), DIM_W'(2), CFG_RGBA);
    repeat (3) send_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFE));
    // Odd width: the third column of each row is dropped.
    set_level(DIM_W'(3), DIM_W'(2), CFG_RGB);
    repeat (6) send_pixel(rand_pixel());
    set_level(DIM_W'(1), DIM_W'(3), CFG_RGBA);
    send_pixel(rgba(8'h00, 8'h01, 8'hFF, 8'h80));
    send_pixel(rgba(8'hFF, 8'h00, 8'hFE, 8'h81));
    send_pixel(rand_pixel());
    set_level(DIM_W'(0), DIM_W'(2), CFG_RGBA);
    repeat (2) send_pixel(rand_pixel());
    set_level(DIM_W'(3), DIM_W'(1), CFG_RGBA);
    repeat (3) send_pixel(rand_pixel());
    set_level(DIM_W'(2), DIM_W'(0), CFG_RGB);
    repeat (2) send_pixel(rand_pixel());
  endtask

  task automatic test_frame_restart();
    set_level(DIM_W'(4), DIM_W'(4), CFG_RGBA);
    repeat (6) send_pixel(rand_pixel());
    drain();
    write_reg(REG_SRC_WIDTH, DIM_W'(4));
    // Two frames back to back, then stop part way through a third.
    repeat (37) send_pixel(rand_pixel());
    drain();
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    repeat (11) send_pixel(rand_pixel());
  endtask

  task automatic test_largest_sizes();
    gap_max   = 0;
    stall_pct = 0;
    // Oversize dimensions saturate; short runs cover the start of the widest and tallest levels.
    set_level(DIM_W'(8191), DIM_W'(1), CFG_RGBA);
    repeat (64) send_pixel(rand_pixel());
    gap_max   = 3;
    stall_pct = 25;
    set_level(DIM_W'(1), DIM_W'(8191), CFG_RGB);
    repeat (64) send_pixel(rand_pixel());
    gap_max   = 0;
    set_level(DIM_W'(MAX_WIDTH), DIM_W'(8191), CFG_RGBA);
    repeat (64) send_pixel(rand_pixel());
  endtask

  task automatic test_back_pressure();
    set_level(DIM_W'(1), DIM_W'(200), CFG_RGBA);
    gap_max      = 0;
    stall_pct    = 0;
    hold_request = LONG_HOLD;
    repeat (200) send_pixel(rand_pixel());
    stall_pct = 70;
    set_level(DIM_W'(16), DIM_W'(8), CFG_RGBA);
    repeat (128) send_pixel(rand_pixel());
  endtask

  task automatic test_random_levels();
    int unsigned w_raw, h_raw, frame_px, n, sent;
    logic [CHAN_W-1:0] chans;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 8;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 25;
        default: stall_pct = 60;
      endcase
      w_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
      h_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
      case ($urandom_range(0, 5))
        0, 1: chans = CHANNELS_RGB;
        2, 3: chans = CHANNELS_RGBA;
        default: chans = CHAN_W'($urandom);
      endcase
      // Spare upper bits of the channel write are ignored by the block.
      set_level(DIM_W'(w_raw), DIM_W'(h_raw), {(CFG_DATA_W - CHAN_W)'($urandom), chans});
      frame_px = clamp_dim(DIM_W'(w_raw), MAX_WIDTH) * clamp_dim(DIM_W'(h_raw), HEIGHT_LIMIT);
      // Mostly whole frames; now and then a frame is cut short by the next write.
      if ($urandom_range(0, 5) == 0) n = $urandom_range(1, frame_px);
      else n = frame_px * $urandom_range(1, 2);
      repeat (n) send_pixel(rand_pixel());
      sent += n;
    end
  endtask

  // Receiver: stall runs of random length, or one long hold when asked for.
  initial begin : receiver_stall
    int unsigned run_left;
    bit          stall_now;
    run_left  = 0;
    stall_now = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_request - 1) @(negedge clk_i);
        hold_request = 0;
        run_left     = 0;
      end else begin
        if (run_left == 0) begin
          stall_now = ($urandom_range(1, 100) <= stall_pct);
          run_left  = $urandom_range(1, 8);
        end
        out_stall_i <= stall_now;
        run_left--;
      end
    end
  end

  task automatic check_lane(input string lane, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, lane, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_stall_o) input_held_cycles++;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (due_mip_pixels.size() == 0) begin
        $display("%0t ns: destination pixel with nothing expected, got %h", $time, out_data_o);
        errors++;
      end else begin
        want_px = due_mip_pixels.pop_front();
        check_lane("red", want_px.red_out, out_data_o.red_out);
        check_lane("green", want_px.green_out, out_data_o.green_out);
        check_lane("blue", want_px.blue_out, out_data_o.blue_out);
        check_lane("alpha", want_px.alpha_out, out_data_o.alpha_out);
        check_lane("level_done", 8'(want_px.level_done), 8'(out_data_o.level_done));
        mip_pixels_seen++;
        if (want_px.level_done) levels_done++;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_copy_and_channels();
    test_small_blocks();
    test_frame_restart();
    test_back_pressure();
    test_largest_sizes();
    test_random_levels();
    drain();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d source pixels over %0d level settings, incl. zero and oversize sizes.",
             src_pixels_sent, levels_set);
    $display("Checked %0d destination pixels, %0d level ends; input held off %0d cycles.",
             mip_pixels_seen, levels_done, input_held_cycles);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/mmbd_pkg.sv
hw/rtl/mmbd_ram.sv
hw/rtl/mipmap_box_downsample.sv
hw/rtl/mmbd_checker.sv
dv/mipmap_box_downsample_tb.sv
